### hdl/rtl_pkg.sv
package rtl_pkg;

    localparam int ENTRIES_DEF = 16;

    localparam logic [4:0]  MAX_ENTRIES_RST = 5'd16;
    localparam logic [47:0] BUDGET_RST      = 48'h0000_8000_0000;

    localparam logic [47:0] M48 = 48'hFFFF_FFFF_FFFF;
    localparam logic [31:0] M32 = 32'hFFFF_FFFF;
    localparam logic [15:0] M16 = 16'hFFFF;

    typedef enum logic [2:0] {
        REQ_LOAD    = 3'd0,
        REQ_TOUCH   = 3'd1,
        REQ_ACQUIRE = 3'd2,
        REQ_RELEASE = 3'd3,
        REQ_ERASE   = 3'd4,
        REQ_FITS    = 3'd5,
        REQ_OLDEST  = 3'd6,
        REQ_EXPIRED = 3'd7
    } t_req;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_EXISTS    = 3'd1,
        ST_OVER      = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_UNBAL     = 3'd4,
        ST_IN_USE    = 3'd5
    } t_status;

    localparam logic [1:0] CFG_MAX_ENTRIES = 2'd0;
    localparam logic [1:0] CFG_BUDGET      = 2'd1;
    localparam logic [1:0] CFG_RESERVE     = 2'd2;
    localparam logic [1:0] CFG_DEFAULT_KA  = 2'd3;

    // controller to datapath
    typedef struct packed {
        logic scan_clear;  // start a scan pass
        logic scan_step;   // examine current slot
        logic act;         // apply the request update
        logic emit;        // load output register
        logic emit_match;  // emit expired match at current slot
        logic emit_last;
        logic emit_none;   // expired query with no match
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic scan_done;   // current slot is the final one
        logic slot_match;  // current slot is an expired match
        logic any_later;   // a later slot still matches
    } t_sts;

endpackage

### hdl/rtl_ctrl.sv
module rtl_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  logic [2:0]      i_req,
    input  logic            i_out_busy,
    input  rtl_pkg::t_sts   i_sts,
    output rtl_pkg::t_cmd   o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_SCAN = 5'b00010,
        S_ACT  = 5'b00100,
        S_LIST = 5'b01000,
        S_EMIT = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic   r_any, n_any;
    logic   accept;

    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = i_in_valid && (r_state == S_IDLE);

    // sequence: scan all slots, then update or list results
    always_comb begin
        n_state = r_state;
        n_any   = r_any;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.scan_clear = 1'b1;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.scan_done) begin
                    if (i_req == rtl_pkg::REQ_EXPIRED) begin
                        o_cmd.scan_clear = 1'b1;
                        n_any   = 1'b0;
                        n_state = S_LIST;
                    end else begin
                        n_state = S_ACT;
                    end
                end
            end
            S_ACT: begin
                if (!i_out_busy) begin
                    o_cmd.act  = 1'b1;
                    o_cmd.emit = 1'b1;
                    n_state    = S_EMIT;
                end
            end
            S_LIST: begin
                if (!i_out_busy) begin
                    if (i_sts.slot_match) begin
                        o_cmd.emit       = 1'b1;
                        o_cmd.emit_match = 1'b1;
                        o_cmd.emit_last  = !i_sts.any_later;
                        n_any = 1'b1;
                    end else if (i_sts.scan_done && !r_any) begin
                        o_cmd.emit      = 1'b1;
                        o_cmd.emit_none = 1'b1;
                    end
                    o_cmd.scan_step = 1'b1;
                    if (i_sts.scan_done) n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (!i_out_busy) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_any   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_any   <= n_any;
        end
    end

    a_stall_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> o_in_stall)
        else $error("input not stalled while busy");
    a_act_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.act |=> !o_cmd.act)
        else $error("update applied twice");
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> !i_out_busy)
        else $error("result emitted over a waiting beat");

endmodule

### hdl/rtl_dp.sv
module rtl_dp #(
    parameter int ENTRIES = rtl_pkg::ENTRIES_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  logic            i_cfg_we,
    input  logic [1:0]      i_cfg_idx,
    input  logic [47:0]     i_cfg_data,
    input  logic [2:0]      i_req_type,
    input  logic [15:0]     i_model_key,
    input  logic [47:0]     i_mem_bytes,
    input  logic signed [32:0] i_keep_alive_ms,
    input  logic [46:0]     i_now_ms,
    input  logic            i_is_eviction,
    input  logic            i_avail_valid,
    input  logic [47:0]     i_avail_bytes,
    input  rtl_pkg::t_cmd   i_cmd,
    output rtl_pkg::t_sts   o_sts,
    output logic [2:0]      o_req,
    input  logic            i_out_take,
    output logic            o_out_valid,
    output logic [2:0]      o_status,
    output logic            o_found_valid,
    output logic [15:0]     o_found_key,
    output logic            o_fits_ok,
    output logic [47:0]     o_used_bytes,
    output logic [4:0]      o_entry_count,
    output logic [31:0]     o_load_count,
    output logic [31:0]     o_eviction_count,
    output logic            o_last
);

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);
    localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);
    // table size as seen by the 5-bit entry limit
    localparam logic [4:0] ENT_CAP = (ENTRIES > 31) ? 5'd31 : 5'(ENTRIES);

    // configuration
    logic [4:0]  r_max_entries;
    logic [47:0] r_budget, r_reserve;
    logic [31:0] r_def_ka;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_entries <= rtl_pkg::MAX_ENTRIES_RST;
            r_budget      <= rtl_pkg::BUDGET_RST;
            r_reserve     <= '0;
            r_def_ka      <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                rtl_pkg::CFG_MAX_ENTRIES: r_max_entries <= i_cfg_data[4:0];
                rtl_pkg::CFG_BUDGET:      r_budget      <= i_cfg_data;
                rtl_pkg::CFG_RESERVE:     r_reserve     <= i_cfg_data;
                rtl_pkg::CFG_DEFAULT_KA:  r_def_ka      <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    // slot storage
    logic [ENTRIES-1:0] r_valid;
    logic [15:0] r_key   [ENTRIES];
    logic [47:0] r_bytes [ENTRIES];
    logic [31:0] r_ka    [ENTRIES];
    logic [47:0] r_exp   [ENTRIES];
    logic [47:0] r_stamp [ENTRIES];
    logic [15:0] r_lease [ENTRIES];
    logic [47:0] r_clock, r_used;
    logic [CW-1:0] r_count;
    logic [31:0] r_loads, r_evicts;

    // latched request
    logic [2:0]  r_req;
    logic [15:0] r_mkey;
    logic [47:0] r_mem, r_avail;
    logic        r_kneg, r_evict, r_av;
    logic [31:0] r_keep;
    logic [46:0] r_now;

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_req   <= i_req_type;
            r_mkey  <= i_model_key;
            r_mem   <= i_mem_bytes;
            r_kneg  <= i_keep_alive_ms[32];
            r_keep  <= i_keep_alive_ms[31:0];
            r_now   <= i_now_ms;
            r_evict <= i_is_eviction;
            r_av    <= i_avail_valid;
            r_avail <= i_avail_bytes;
        end
    end
    assign o_req = r_req;

    // scan registers
    logic [IW-1:0] r_idx;
    logic          r_hit, r_free_ok, r_best_ok;
    logic [IW-1:0] r_hit_idx, r_free_idx, r_best_idx;
    logic [47:0]   r_best_stamp;
    logic [ENTRIES-1:0] expm;

    always_comb begin
        for (int k = 0; k < ENTRIES; k++)
            expm[k] = r_valid[k] && (r_lease[k] == '0) &&
                      ({1'b0, r_now} >= r_exp[k]);
    end

    logic later;
    always_comb begin
        later = 1'b0;
        for (int k = 0; k < ENTRIES; k++)
            if (IW'(k) > r_idx && expm[k]) later = 1'b1;
    end

    assign o_sts.scan_done  = (r_idx == LAST_IDX);
    assign o_sts.slot_match = expm[r_idx];
    assign o_sts.any_later  = later;

    // walk the slots one per cycle, pausing in the listing pass while the output is stalled
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_clear) begin
            r_idx     <= '0;
            r_hit     <= 1'b0;
            r_free_ok <= 1'b0;
            r_best_ok <= 1'b0;
        end else if (i_cmd.scan_step) begin
            if (r_idx != LAST_IDX) r_idx <= r_idx + 1'b1;
            if (r_valid[r_idx] && r_key[r_idx] == r_mkey && !r_hit) begin
                r_hit     <= 1'b1;
                r_hit_idx <= r_idx;
            end
            if (!r_valid[r_idx] && !r_free_ok) begin
                r_free_ok  <= 1'b1;
                r_free_idx <= r_idx;
            end
            if (r_valid[r_idx] && r_lease[r_idx] == '0 &&
                (!r_best_ok || r_stamp[r_idx] < r_best_stamp)) begin
                r_best_ok    <= 1'b1;
                r_best_idx   <= r_idx;
                r_best_stamp <= r_stamp[r_idx];
            end
        end
    end

    // fit test on the running totals
    logic [4:0]  lim;
    logic [47:0] room;
    logic fit_base, fit_avail;
    assign lim  = (r_max_entries < ENT_CAP) ? r_max_entries : ENT_CAP;
    assign room = r_budget - r_used;
    assign fit_base = (5'(r_count) < lim) && (r_used <= r_budget) && (r_mem <= room);
    assign fit_avail = (r_avail >= r_reserve) && (r_mem <= r_avail - r_reserve);

    logic [47:0] stamp_n;
    assign stamp_n = (r_clock != rtl_pkg::M48) ? r_clock + 48'd1 : r_clock;

    // decide status and update
    logic [2:0] st;
    logic [IW-1:0] ti;
    logic [31:0] ka_use;
    logic [47:0] now48;
    assign now48 = {1'b0, r_now};
    assign ti    = r_hit_idx;

    always_comb begin
        st = rtl_pkg::ST_OK;
        case (r_req)
            rtl_pkg::REQ_LOAD: begin
                if (r_hit) st = rtl_pkg::ST_EXISTS;
                else if (!fit_base || !r_free_ok) st = rtl_pkg::ST_OVER;
            end
            rtl_pkg::REQ_TOUCH, rtl_pkg::REQ_ACQUIRE: begin
                if (!r_hit) st = rtl_pkg::ST_NOT_FOUND;
            end
            rtl_pkg::REQ_RELEASE: begin
                if (!r_hit) st = rtl_pkg::ST_NOT_FOUND;
                else if (r_lease[ti] == '0) st = rtl_pkg::ST_UNBAL;
            end
            rtl_pkg::REQ_ERASE: begin
                if (r_hit && r_lease[ti] != '0) st = rtl_pkg::ST_IN_USE;
            end
            default: st = rtl_pkg::ST_OK;
        endcase
    end

    always_comb begin
        ka_use = r_ka[ti];
        if (r_req == rtl_pkg::REQ_LOAD) ka_use = r_kneg ? r_def_ka : r_keep;
        else if ((r_req == rtl_pkg::REQ_TOUCH || r_req == rtl_pkg::REQ_ACQUIRE) && !r_kneg)
            ka_use = r_keep;
    end

    logic upd;
    assign upd = i_cmd.act && (st == rtl_pkg::ST_OK);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_clock  <= '0;
            r_used   <= '0;
            r_count  <= '0;
            r_loads  <= '0;
            r_evicts <= '0;
        end else if (upd) begin
            case (r_req)
                rtl_pkg::REQ_LOAD: begin
                    r_valid[r_free_idx] <= 1'b1;
                    r_key[r_free_idx]   <= r_mkey;
                    r_bytes[r_free_idx] <= r_mem;
                    r_lease[r_free_idx] <= '0;
                    r_ka[r_free_idx]    <= ka_use;
                    r_stamp[r_free_idx] <= stamp_n;
                    r_exp[r_free_idx]   <= now48 + {16'd0, ka_use};
                    r_clock <= stamp_n;
                    r_used  <= r_used + r_mem;
                    r_count <= r_count + 1'b1;
                    if (r_loads != rtl_pkg::M32) r_loads <= r_loads + 32'd1;
                end
                rtl_pkg::REQ_TOUCH, rtl_pkg::REQ_ACQUIRE, rtl_pkg::REQ_RELEASE: begin
                    r_ka[ti]    <= ka_use;
                    r_stamp[ti] <= stamp_n;
                    r_exp[ti]   <= now48 + {16'd0, ka_use};
                    r_clock     <= stamp_n;
                    if (r_req == rtl_pkg::REQ_ACQUIRE && r_lease[ti] != rtl_pkg::M16)
                        r_lease[ti] <= r_lease[ti] + 16'd1;
                    if (r_req == rtl_pkg::REQ_RELEASE)
                        r_lease[ti] <= r_lease[ti] - 16'd1;
                end
                rtl_pkg::REQ_ERASE: begin
                    if (r_hit) begin
                        r_valid[ti] <= 1'b0;
                        r_used  <= r_used - r_bytes[ti];
                        r_count <= r_count - 1'b1;
                        if (r_evict && r_evicts != rtl_pkg::M32)
                            r_evicts <= r_evicts + 32'd1;
                    end
                end
                default: ;
            endcase
        end
    end

    // post-step totals for the outgoing beat
    logic [47:0] used_n;
    logic [CW-1:0] cnt_n;
    logic [31:0] loads_n, ev_n;
    always_comb begin
        used_n  = r_used;
        cnt_n   = r_count;
        loads_n = r_loads;
        ev_n    = r_evicts;
        if (upd && r_req == rtl_pkg::REQ_LOAD) begin
            used_n = r_used + r_mem;
            cnt_n  = r_count + 1'b1;
            if (r_loads != rtl_pkg::M32) loads_n = r_loads + 32'd1;
        end else if (upd && r_req == rtl_pkg::REQ_ERASE && r_hit) begin
            used_n = r_used - r_bytes[ti];
            cnt_n  = r_count - 1'b1;
            if (r_evict && r_evicts != rtl_pkg::M32) ev_n = r_evicts + 32'd1;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            o_out_valid <= 1'b1;
        end else if (i_out_take) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_used_bytes     <= used_n;
            o_entry_count    <= 5'(cnt_n);
            o_load_count     <= loads_n;
            o_eviction_count <= ev_n;
            o_fits_ok        <= 1'b0;
            o_found_valid    <= 1'b0;
            o_found_key      <= '0;
            o_last           <= 1'b1;
            o_status         <= i_cmd.act ? st : rtl_pkg::ST_OK;
            if (i_cmd.emit_match) begin
                o_found_valid <= 1'b1;
                o_found_key   <= r_key[r_idx];
                o_last        <= i_cmd.emit_last;
            end else if (i_cmd.act && r_req == rtl_pkg::REQ_FITS) begin
                o_fits_ok <= fit_base && (!r_av || fit_avail);
            end else if (i_cmd.act && r_req == rtl_pkg::REQ_OLDEST && r_best_ok) begin
                o_found_valid <= 1'b1;
                o_found_key   <= r_key[r_best_idx];
            end
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(ENTRIES))
        else $error("entry count beyond table size");
    a_emit_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_take && !i_cmd.emit) |=> o_out_valid)
        else $error("result beat dropped");
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (upd && r_req == rtl_pkg::REQ_LOAD) |-> !r_valid[r_free_idx])
        else $error("load into occupied slot");

endmodule

### hdl/residency_table_lru_ttl.sv
// Residency table of up to ENTRIES keyed entries with LRU stamps and TTL expiry.
// Each request scans the slots one per cycle via the shared compare unit, then
// applies its update and emits its result; the expired query instead lists its
// matches in a second pass, one beat each, waiting while the output is stalled.
// Configuration writes are taken at any time but belong while the block is idle.
module residency_table_lru_ttl #(
    parameter int ENTRIES = rtl_pkg::ENTRIES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [47:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [2:0]         i_req_type,
    input  logic [15:0]        i_model_key,
    input  logic [47:0]        i_mem_bytes,
    input  logic signed [32:0] i_keep_alive_ms,
    input  logic [46:0]        i_now_ms,
    input  logic               i_is_eviction,
    input  logic               i_avail_valid,
    input  logic [47:0]        i_avail_bytes,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [2:0]         o_status,
    output logic               o_found_valid,
    output logic [15:0]        o_found_key,
    output logic               o_fits_ok,
    output logic [47:0]        o_used_bytes,
    output logic [4:0]         o_entry_count,
    output logic [31:0]        o_load_count,
    output logic [31:0]        o_eviction_count,
    output logic               o_last
);

    rtl_pkg::t_cmd cmd;
    rtl_pkg::t_sts sts;
    logic [2:0]    req;
    logic          accept, busy;

    assign accept = i_in_valid && !o_in_stall;
    assign busy   = o_out_valid && i_out_stall;

    rtl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_req      (req),
        .i_out_busy (busy),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    rtl_dp #(.ENTRIES(ENTRIES)) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (accept),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_req_type       (i_req_type),
        .i_model_key      (i_model_key),
        .i_mem_bytes      (i_mem_bytes),
        .i_keep_alive_ms  (i_keep_alive_ms),
        .i_now_ms         (i_now_ms),
        .i_is_eviction    (i_is_eviction),
        .i_avail_valid    (i_avail_valid),
        .i_avail_bytes    (i_avail_bytes),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .o_req            (req),
        .i_out_take       (!i_out_stall),
        .o_out_valid      (o_out_valid),
        .o_status         (o_status),
        .o_found_valid    (o_found_valid),
        .o_found_key      (o_found_key),
        .o_fits_ok        (o_fits_ok),
        .o_used_bytes     (o_used_bytes),
        .o_entry_count    (o_entry_count),
        .o_load_count     (o_load_count),
        .o_eviction_count (o_eviction_count),
        .o_last           (o_last)
    );

endmodule

### bench/tb_residency_table_lru_ttl.sv
module tb_residency_table_lru_ttl;

    localparam int SLOTS = 16;

    typedef struct {
        rtl_pkg::t_req      req;
        logic [15:0]        key;
        logic [47:0]        mem;
        logic signed [32:0] ka;
        logic [46:0]        now;
        logic               evict;
        logic               av;
        logic [47:0]        avail;
    } t_item;

    typedef struct {
        logic [2:0]  status;
        logic        fv;
        logic [15:0] fk;
        logic        fo;
        logic [47:0] used;
        logic [4:0]  cnt;
        logic [31:0] loads;
        logic [31:0] evicts;
        logic        last;
    } t_beat;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [1:0]         i_cfg_idx = '0;
    logic [47:0]        i_cfg_data = '0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic [2:0]         i_req_type = '0;
    logic [15:0]        i_model_key = '0;
    logic [47:0]        i_mem_bytes = '0;
    logic signed [32:0] i_keep_alive_ms = '0;
    logic [46:0]        i_now_ms = '0;
    logic               i_is_eviction = 1'b0;
    logic               i_avail_valid = 1'b0;
    logic [47:0]        i_avail_bytes = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic [2:0]         o_status;
    logic               o_found_valid;
    logic [15:0]        o_found_key;
    logic               o_fits_ok;
    logic [47:0]        o_used_bytes;
    logic [4:0]         o_entry_count;
    logic [31:0]        o_load_count;
    logic [31:0]        o_eviction_count;
    logic               o_last;

    residency_table_lru_ttl uut (.*);

    // table model
    bit          tbl_valid [SLOTS];
    bit [15:0]   tbl_key   [SLOTS];
    bit [47:0]   tbl_bytes [SLOTS];
    bit [31:0]   tbl_ka    [SLOTS];
    bit [47:0]   tbl_exp   [SLOTS];
    bit [47:0]   tbl_stamp [SLOTS];
    bit [15:0]   tbl_lease [SLOTS];
    bit [47:0]   stamp_clk;
    bit [31:0]   n_loads, n_evicts;
    bit [4:0]    cfg_max;
    bit [47:0]   cfg_budget, cfg_reserve;
    bit [31:0]   cfg_def_ka;

    t_beat       expect_q [$];
    int          err_count = 0;
    int          tx_idle = 0;
    int          rx_idle = 0;
    int          hold_req = 0;
    bit [46:0]   t_base = 0;

    always #1 i_clk = ~i_clk;

    initial begin
        #2000000;
        $display("tb: failure");
        $finish;
    end

    function automatic int find_key(bit [15:0] k);
        for (int s = 0; s < SLOTS; s++)
            if (tbl_valid[s] && tbl_key[s] == k) return s;
        return -1;
    endfunction

    function automatic bit [63:0] used_total();
        bit [63:0] sum = 0;
        for (int s = 0; s < SLOTS; s++) if (tbl_valid[s]) sum += tbl_bytes[s];
        return sum;
    endfunction

    function automatic int live_count();
        int c = 0;
        for (int s = 0; s < SLOTS; s++) if (tbl_valid[s]) c++;
        return c;
    endfunction

    function automatic bit room_for(bit [47:0] need, bit use_av, bit [47:0] av);
        bit [63:0] used;
        int lim;
        used = used_total();
        lim = (cfg_max < SLOTS) ? cfg_max : SLOTS;
        if (!(live_count() < lim && used <= cfg_budget && need <= cfg_budget - used))
            return 1'b0;
        if (use_av && !(av >= cfg_reserve && need <= av - cfg_reserve)) return 1'b0;
        return 1'b1;
    endfunction

    function automatic void restamp(int s, bit has_ka, bit [31:0] ka, bit [46:0] now);
        if (has_ka) tbl_ka[s] = ka;
        if (stamp_clk != rtl_pkg::M48) stamp_clk++;
        tbl_stamp[s] = stamp_clk;
        tbl_exp[s] = {1'b0, now} + {16'd0, tbl_ka[s]};
    endfunction

    function automatic void push_beat(rtl_pkg::t_status st, bit fv, bit [15:0] fk, bit fo,
                                      bit last);
        t_beat b;
        b.status = st;
        b.fv = fv;
        b.fk = fk;
        b.fo = fo;
        b.used = 48'(used_total());
        b.cnt = 5'(live_count());
        b.loads = n_loads;
        b.evicts = n_evicts;
        b.last = last;
        expect_q.push_back(b);
    endfunction

    // work out the beats caused by one accepted request
    function automatic void apply_req(t_item r);
        int s, j, best, n;
        bit kneg;
        rtl_pkg::t_status st;
        kneg = r.ka[32];
        s = find_key(r.key);
        st = rtl_pkg::ST_OK;
        case (r.req)
            rtl_pkg::REQ_LOAD: begin
                if (s >= 0) st = rtl_pkg::ST_EXISTS;
                else if (!room_for(r.mem, 1'b0, '0)) st = rtl_pkg::ST_OVER;
                else begin
                    for (j = 0; j < SLOTS; j++) if (!tbl_valid[j]) break;
                    tbl_valid[j] = 1'b1;
                    tbl_key[j] = r.key;
                    tbl_bytes[j] = r.mem;
                    tbl_lease[j] = 0;
                    restamp(j, 1'b1, kneg ? cfg_def_ka : r.ka[31:0], r.now);
                    if (n_loads != rtl_pkg::M32) n_loads++;
                end
            end
            rtl_pkg::REQ_TOUCH, rtl_pkg::REQ_ACQUIRE: begin
                if (s < 0) st = rtl_pkg::ST_NOT_FOUND;
                else begin
                    restamp(s, !kneg, r.ka[31:0], r.now);
                    if (r.req == rtl_pkg::REQ_ACQUIRE && tbl_lease[s] != rtl_pkg::M16)
                        tbl_lease[s]++;
                end
            end
            rtl_pkg::REQ_RELEASE: begin
                if (s < 0) st = rtl_pkg::ST_NOT_FOUND;
                else if (tbl_lease[s] == 0) st = rtl_pkg::ST_UNBAL;
                else begin
                    tbl_lease[s]--;
                    restamp(s, 1'b0, '0, r.now);
                end
            end
            rtl_pkg::REQ_ERASE: begin
                if (s >= 0) begin
                    if (tbl_lease[s] != 0) st = rtl_pkg::ST_IN_USE;
                    else begin
                        tbl_valid[s] = 1'b0;
                        if (r.evict && n_evicts != rtl_pkg::M32) n_evicts++;
                    end
                end
            end
            rtl_pkg::REQ_FITS: begin
                push_beat(rtl_pkg::ST_OK, 1'b0, '0, room_for(r.mem, r.av, r.avail), 1'b1);
                return;
            end
            rtl_pkg::REQ_OLDEST: begin
                best = -1;
                for (j = 0; j < SLOTS; j++)
                    if (tbl_valid[j] && tbl_lease[j] == 0 &&
                        (best < 0 || tbl_stamp[j] < tbl_stamp[best])) best = j;
                if (best < 0) push_beat(rtl_pkg::ST_OK, 1'b0, '0, 1'b0, 1'b1);
                else push_beat(rtl_pkg::ST_OK, 1'b1, tbl_key[best], 1'b0, 1'b1);
                return;
            end
            default: begin
                n = 0;
                for (j = 0; j < SLOTS; j++)
                    if (tbl_valid[j] && tbl_lease[j] == 0 && {1'b0, r.now} >= tbl_exp[j]) begin
                        push_beat(rtl_pkg::ST_OK, 1'b1, tbl_key[j], 1'b0, 1'b0);
                        n++;
                    end
                if (n == 0) push_beat(rtl_pkg::ST_OK, 1'b0, '0, 1'b0, 1'b1);
                else expect_q[$].last = 1'b1;
                return;
            end
        endcase
        push_beat(st, 1'b0, '0, 1'b0, 1'b1);
    endfunction

    // compare each accepted result beat with the oldest expectation
    always @(posedge i_clk) begin
        t_beat e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expect_q.size() == 0) begin
                err_count++;
                if (err_count <= 10) $display("unexpected result beat, key %h", o_found_key);
            end else begin
                e = expect_q.pop_front();
                if (o_status !== e.status || o_found_valid !== e.fv || o_found_key !== e.fk ||
                    o_fits_ok !== e.fo || o_used_bytes !== e.used ||
                    o_entry_count !== e.cnt || o_load_count !== e.loads ||
                    o_eviction_count !== e.evicts || o_last !== e.last) begin
                    err_count++;
                    if (err_count <= 10)
                        $display("mismatch exp st%0d fv%0d k%h fo%0d u%h c%0d l%0d e%0d z%0d",
                                 e.status, e.fv, e.fk, e.fo, e.used, e.cnt, e.loads,
                                 e.evicts, e.last,
                                 " got st%0d fv%0d k%h fo%0d u%h c%0d l%0d e%0d z%0d",
                                 o_status, o_found_valid, o_found_key, o_fits_ok,
                                 o_used_bytes, o_entry_count, o_load_count,
                                 o_eviction_count, o_last);
                end
            end
        end
    end

    // drive output stall: random, or a long hold when asked
    always @(posedge i_clk) begin
        int hold_left;
        if (hold_req > 0) begin
            hold_left = hold_req;
            hold_req = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < rx_idle);
        end
    end

    task automatic send_req(input t_item r);
        while ($urandom_range(99) < tx_idle) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_req_type <= r.req;
        i_model_key <= r.key;
        i_mem_bytes <= r.mem;
        i_keep_alive_ms <= r.ka;
        i_now_ms <= r.now;
        i_is_eviction <= r.evict;
        i_avail_valid <= r.av;
        i_avail_bytes <= r.avail;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        apply_req(r);
    endtask

    // hold off until every expected beat is in, then let the block settle
    task automatic drain();
        i_in_valid <= 1'b0;
        while (expect_q.size() != 0) @(posedge i_clk);
        repeat (3 * SLOTS + 10) @(posedge i_clk);
    endtask

    task automatic write_cfg(logic [1:0] idx, logic [47:0] val);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            rtl_pkg::CFG_MAX_ENTRIES: cfg_max = val[4:0];
            rtl_pkg::CFG_BUDGET:      cfg_budget = val;
            rtl_pkg::CFG_RESERVE:     cfg_reserve = val;
            default:                  cfg_def_ka = val[31:0];
        endcase
    endtask

    function automatic t_item mk_req(rtl_pkg::t_req q, bit [15:0] k, bit [47:0] m,
                                     logic signed [32:0] ka, bit [46:0] now);
        t_item r;
        r.req = q;
        r.key = k;
        r.mem = m;
        r.ka = ka;
        r.now = now;
        r.evict = 1'($urandom_range(1));
        r.av = 1'($urandom_range(1));
        r.avail = 48'({$urandom, $urandom});
        return r;
    endfunction

    function automatic t_item rand_req();
        t_item r;
        int p;
        p = $urandom_range(99);
        r.req = (p < 30) ? rtl_pkg::REQ_LOAD : rtl_pkg::t_req'($urandom_range(7));
        r.key = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(19));
        case ($urandom_range(5))
            0:       r.mem = 48'({$urandom, $urandom});
            1:       r.mem = 48'($urandom_range(1 << 30, 0));
            default: r.mem = 48'($urandom_range(4000));
        endcase
        case ($urandom_range(5))
            0:       r.ka = -33'sd1;
            1:       r.ka = {1'b0, 32'($urandom)};
            default: r.ka = 33'($urandom_range(60));
        endcase
        t_base += 47'($urandom_range(12));
        r.now = ($urandom_range(15) == 0) ? 47'({$urandom, $urandom}) : t_base;
        r.evict = 1'($urandom_range(1));
        r.av = 1'($urandom_range(1));
        r.avail = ($urandom_range(1) == 0) ? 48'({$urandom, $urandom})
                                           : 48'($urandom_range(1 << 20));
        return r;
    endfunction

    task automatic test_directed();
        t_item r;
        send_req(mk_req(rtl_pkg::REQ_EXPIRED, 16'h0, '0, -33'sd1, '0));
        send_req(mk_req(rtl_pkg::REQ_OLDEST, 16'h0, '0, -33'sd1, '0));
        send_req(mk_req(rtl_pkg::REQ_LOAD, 16'h0005, 48'd0, 33'sd100, 47'd0));
        send_req(mk_req(rtl_pkg::REQ_LOAD, 16'h0005, 48'd10, 33'sd1, 47'd0));
        send_req(mk_req(rtl_pkg::REQ_LOAD, 16'hFFFF, rtl_pkg::M48, 33'sd1, 47'd0));
        send_req(mk_req(rtl_pkg::REQ_LOAD, 16'hFFFF, 48'd12, {1'b0, rtl_pkg::M32}, '1));
        send_req(mk_req(rtl_pkg::REQ_LOAD, 16'h0000, 48'd7, -33'sd1, 47'd5));
        r = mk_req(rtl_pkg::REQ_FITS, 16'h0, 48'h8000_0000, -33'sd1, '0);
        r.av = 1'b0;
        send_req(r);
        r.av = 1'b1;
        r.avail = 48'd3;
        send_req(r);
        r.avail = rtl_pkg::M48;
        send_req(r);
        send_req(mk_req(rtl_pkg::REQ_TOUCH, 16'h1234, '0, 33'sd1, '0));
        send_req(mk_req(rtl_pkg::REQ_TOUCH, 16'h0005, '0, -33'sd1, 47'd10));
        send_req(mk_req(rtl_pkg::REQ_ACQUIRE, 16'h0005, '0, 33'sd0, 47'd20));
        send_req(mk_req(rtl_pkg::REQ_ERASE, 16'h0005, '0, 33'sd0, '0));
        send_req(mk_req(rtl_pkg::REQ_OLDEST, 16'h0, '0, 33'sd0, '0));
        send_req(mk_req(rtl_pkg::REQ_RELEASE, 16'h0005, '0, 33'sd0, 47'd30));
        send_req(mk_req(rtl_pkg::REQ_RELEASE, 16'h0005, '0, 33'sd0, 47'd31));
        send_req(mk_req(rtl_pkg::REQ_RELEASE, 16'h4321, '0, 33'sd0, 47'd31));
        send_req(mk_req(rtl_pkg::REQ_EXPIRED, 16'h0, '0, 33'sd0, 47'd40));
        send_req(mk_req(rtl_pkg::REQ_EXPIRED, 16'h0, '0, 33'sd0, '1));
        r = mk_req(rtl_pkg::REQ_ERASE, 16'h0005, '0, 33'sd0, '0);
        r.evict = 1'b1;
        send_req(r);
        r.evict = 1'b0;
        r.key = 16'h0000;
        send_req(r);
        send_req(mk_req(rtl_pkg::REQ_ERASE, 16'h7777, '0, 33'sd0, '0));
        drain();
    endtask

    task automatic test_config_extremes();
        write_cfg(rtl_pkg::CFG_MAX_ENTRIES, 48'd0);
        write_cfg(rtl_pkg::CFG_DEFAULT_KA, {16'h0, rtl_pkg::M32});
        send_req(mk_req(rtl_pkg::REQ_LOAD, 16'h0009, 48'd1, -33'sd1, 47'd1));
        send_req(mk_req(rtl_pkg::REQ_FITS, 16'h0, 48'd0, 33'sd0, '0));
        write_cfg(rtl_pkg::CFG_MAX_ENTRIES, 48'd31);
        write_cfg(rtl_pkg::CFG_BUDGET, rtl_pkg::M48);
        write_cfg(rtl_pkg::CFG_RESERVE, rtl_pkg::M48);
        send_req(mk_req(rtl_pkg::REQ_LOAD, 16'h0009, rtl_pkg::M48, -33'sd1, 47'd1));
        send_req(mk_req(rtl_pkg::REQ_FITS, 16'h0, 48'd0, 33'sd0, '0));
        write_cfg(rtl_pkg::CFG_BUDGET, 48'd0);
        send_req(mk_req(rtl_pkg::REQ_LOAD, 16'h000A, 48'd0, 33'sd1, 47'd1));
        send_req(mk_req(rtl_pkg::REQ_FITS, 16'h0, 48'd0, 33'sd0, '0));
        send_req(mk_req(rtl_pkg::REQ_ERASE, 16'h0009, '0, 33'sd0, '0));
        drain();
    endtask

    task automatic test_random(int tx, int rx, int n, bit [4:0] maxe, bit [47:0] budget);
        tx_idle = tx;
        rx_idle = rx;
        write_cfg(rtl_pkg::CFG_MAX_ENTRIES, {43'd0, maxe});
        write_cfg(rtl_pkg::CFG_BUDGET, budget);
        write_cfg(rtl_pkg::CFG_RESERVE, 48'($urandom_range(1 << 16)));
        write_cfg(rtl_pkg::CFG_DEFAULT_KA, 48'($urandom_range(40)));
        for (int k = 0; k < n; k++) begin
            send_req(rand_req());
            // pause the sender once, halfway, until the table has answered
            if (k == n / 2) drain();
        end
        drain();
    endtask

    task automatic test_backpressure();
        tx_idle = 0;
        rx_idle = 0;
        hold_req = 400;
        for (int k = 0; k < 12; k++) send_req(rand_req());
        send_req(mk_req(rtl_pkg::REQ_EXPIRED, 16'h0, '0, 33'sd0, '1));
        drain();
    endtask

    initial begin
        stamp_clk = 0;
        n_loads = 0;
        n_evicts = 0;
        cfg_max = rtl_pkg::MAX_ENTRIES_RST;
        cfg_budget = rtl_pkg::BUDGET_RST;
        cfg_reserve = 0;
        cfg_def_ka = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_config_extremes();
        test_random(24, 49, 70, 5'd16, 48'h10_0000_0000);
        test_random(49, 24, 70, 5'd6, 48'd20000);
        test_random(0, 0, 70, 5'd16, rtl_pkg::M48);
        test_backpressure();
        repeat (50) @(posedge i_clk);
        if (err_count == 0 && expect_q.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
